[src/path_oram_controller_unit_assert.svh]
// Assertion macros for the path ORAM controller unit.
// Used by path_oram_controller_unit.sv; the enclosing module supplies clk and rst_n.
`ifndef PATH_ORAM_CONTROLLER_UNIT_ASSERT_SVH
`define PATH_ORAM_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define POC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("path oram controller check failed");
// Expression that must never be true.
`define POC_NEVER(lbl, expr) \
    `POC_ASSERT(lbl, !(expr))
`else
`define POC_ASSERT(lbl, prop)
`define POC_NEVER(lbl, expr)
`endif
`endif

[src/poc_pkg.sv]
// Shared constants, word types and path helpers for the path ORAM controller.
// No dependencies.
package poc_pkg;

    localparam int TREE_LEVELS  = 8;
    localparam int BUCKET_SLOTS = 4;
    localparam int STASH_DEPTH  = 64;
    localparam int ADDR_BITS    = 10;
    localparam int DATA_BITS    = 64;
    localparam int META_BITS    = 16;

    localparam int LEAF_BITS   = TREE_LEVELS - 1;
    localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
    localparam int SLOT_COUNT  = NODE_COUNT * BUCKET_SLOTS;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int ADDR_SPACE  = 1 << ADDR_BITS;
    localparam int CLR_DEPTH   = (ADDR_SPACE > SLOT_COUNT) ? ADDR_SPACE : SLOT_COUNT;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int LVL_W       = (TREE_LEVELS > 2) ? $clog2(TREE_LEVELS) : 1;
    localparam int CNT_W       = $clog2(BUCKET_SLOTS + 1);
    localparam int STASH_W     = $clog2(STASH_DEPTH);

    // Request word
    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] write_data;
        logic [META_BITS-1:0] write_meta;
        logic [LEAF_BITS-1:0] new_leaf;
    } req_t;

    // Response word
    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic [META_BITS-1:0] read_meta;
        logic                 hit;
        logic [LEAF_BITS-1:0] old_leaf;
        logic                 stash_full;
    } rsp_t;

    // One stored block
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [LEAF_BITS-1:0] leaf;
        logic [DATA_BITS-1:0] data;
        logic [META_BITS-1:0] meta;
    } blk_t;

    // One tree slot
    typedef struct packed {
        logic valid;
        blk_t blk;
    } slot_t;

    // Controller to datapath
    typedef struct packed {
        logic               clr_wr;
        logic [CLR_W-1:0]   clr_idx;
        logic               load;
        logic               pm_chk;
        logic [LVL_W-1:0]   lvl;
        logic [CNT_W-1:0]   slot;
        logic               slot_put;
        logic [STASH_W-1:0] st_k;
        logic [STASH_W-1:0] chk_k;
        logic               find_chk;
        logic               update;
        logic               wb_chk;
        logic               wb_fill;
        logic               out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic match;
        logic take;
        logic out_room;
    } stat_t;

    // Slot index of bucket entry 'slot' at depth 'lvl' on the path to 'leaf'
    function automatic logic [SLOT_W-1:0] slot_index(
        input logic [LEAF_BITS-1:0] leaf,
        input logic [LVL_W-1:0]     lvl,
        input logic [CNT_W-1:0]     slot
    );
        logic [TREE_LEVELS-1:0] off;
        logic [TREE_LEVELS-1:0] node;
        off = '0;
        // leaf bit 0 picks the first branch, so it ends up as the MSB of the offset
        for (int i = 0; i < LEAF_BITS; i++) begin
            if (i < int'(lvl)) begin
                off = {off[TREE_LEVELS-2:0], leaf[i]};
            end
        end
        node = (TREE_LEVELS'(1) << lvl) - TREE_LEVELS'(1) + off;
        return SLOT_W'(int'(node) * BUCKET_SLOTS + int'(slot));
    endfunction

    // Low 'lvl' leaf bits set
    function automatic logic [LEAF_BITS-1:0] leaf_mask(input logic [LVL_W-1:0] lvl);
        return ~({LEAF_BITS{1'b1}} << lvl);
    endfunction

endpackage

[src/poc_ctrl.sv]
// Controller state machine for the path ORAM controller.
// Depends on poc_pkg; drives poc_dp through cmd_t and reads stat_t.
module poc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  poc_pkg::stat_t  stat,
    output poc_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PMAP   = 4'd2;
    localparam logic [3:0] S_PCHK   = 4'd3;
    localparam logic [3:0] S_PATH   = 4'd4;
    localparam logic [3:0] S_FIND   = 4'd5;
    localparam logic [3:0] S_UPDATE = 4'd6;
    localparam logic [3:0] S_WBSCAN = 4'd7;
    localparam logic [3:0] S_WBFILL = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [poc_pkg::LVL_W-1:0]   LVL_TOP = poc_pkg::LVL_W'(poc_pkg::TREE_LEVELS - 1);
    localparam logic [poc_pkg::CNT_W-1:0]   SLOTS   = poc_pkg::CNT_W'(poc_pkg::BUCKET_SLOTS);
    localparam logic [poc_pkg::STASH_W:0]   SDEPTH  = (poc_pkg::STASH_W + 1)'(poc_pkg::STASH_DEPTH);
    localparam logic [poc_pkg::CLR_W-1:0]   CLR_END = poc_pkg::CLR_W'(poc_pkg::CLR_DEPTH - 1);

    logic [3:0]                   state_reg, state_next;
    logic [poc_pkg::CLR_W-1:0]    clr_reg, clr_next;
    logic [poc_pkg::LVL_W-1:0]    lvl_reg, lvl_next;
    logic [poc_pkg::CNT_W-1:0]    j_reg, j_next;
    logic [poc_pkg::STASH_W:0]    k_reg, k_next;
    logic                         chk_reg, chk_next;
    logic [poc_pkg::STASH_W-1:0]  chk_k_reg, chk_k_next;
    logic                         iss_done_reg, iss_done_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        lvl_next      = lvl_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        chk_next      = 1'b0;
        chk_k_next    = chk_k_reg;
        iss_done_next = iss_done_reg;
        cmd           = '0;
        cmd.clr_idx   = clr_reg;
        cmd.lvl       = lvl_reg;
        cmd.slot      = j_reg;
        cmd.st_k      = k_reg[poc_pkg::STASH_W-1:0];
        cmd.chk_k     = chk_k_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (clr_reg == CLR_END)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PMAP;
                end
            end
            S_PMAP:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.pm_chk    = 1'b1;
                lvl_next      = '0;
                j_next        = '0;
                iss_done_next = 1'b0;
                state_next    = stat.skip ? S_DONE : S_PATH;
            end
            // read the path, one slot a cycle, each slot checked once its read data is registered
            S_PATH:
            begin
                cmd.slot_put = chk_reg;
                if (!iss_done_reg)
                begin
                    chk_next = 1'b1;
                    if (j_reg == SLOTS - 1'b1)
                    begin
                        j_next = '0;
                        if (lvl_reg == LVL_TOP)
                        begin
                            iss_done_next = 1'b1;
                        end
                        else
                        begin
                            lvl_next = lvl_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else if (!chk_reg)
                begin
                    k_next     = '0;
                    state_next = S_FIND;
                end
            end
            // scan the stash for the addressed block
            S_FIND:
            begin
                cmd.find_chk = chk_reg;
                if (stat.match)
                begin
                    state_next = S_UPDATE;
                end
                else if (k_reg < SDEPTH)
                begin
                    chk_next   = 1'b1;
                    chk_k_next = k_reg[poc_pkg::STASH_W-1:0];
                    k_next     = k_reg + 1'b1;
                end
                else if (!chk_reg)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                lvl_next   = LVL_TOP;
                j_next     = '0;
                k_next     = '0;
                state_next = S_WBSCAN;
            end
            // scan the stash for blocks that fit this bucket
            S_WBSCAN:
            begin
                cmd.wb_chk = chk_reg;
                if (stat.take)
                begin
                    j_next = j_reg + 1'b1;
                end
                if (j_reg == SLOTS)
                begin
                    state_next = S_WBFILL;
                end
                else if (k_reg < SDEPTH)
                begin
                    chk_next   = 1'b1;
                    chk_k_next = k_reg[poc_pkg::STASH_W-1:0];
                    k_next     = k_reg + 1'b1;
                end
                else if (!chk_reg)
                begin
                    state_next = S_WBFILL;
                end
            end
            // empty the rest of the bucket, then move one level up or, at the root, finish
            S_WBFILL:
            begin
                if (j_reg < SLOTS)
                begin
                    cmd.wb_fill = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_WBSCAN;
                end
            end
            S_DONE:
            begin
                if (stat.out_room)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            lvl_reg      <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            chk_reg      <= 1'b0;
            chk_k_reg    <= '0;
            iss_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            lvl_reg      <= lvl_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            chk_reg      <= chk_next;
            chk_k_reg    <= chk_k_next;
            iss_done_reg <= iss_done_next;
        end
    end

endmodule

[src/poc_dp.sv]
// Datapath for the path ORAM controller: position map, bucket tree, stash, result word.
// Depends on poc_pkg; commanded by poc_ctrl.
module poc_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  poc_pkg::req_t   req,
    input  poc_pkg::cmd_t   cmd,
    output poc_pkg::stat_t  stat,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output poc_pkg::rsp_t   rsp
);

    localparam logic [poc_pkg::CNT_W-1:0] SLOTS = poc_pkg::CNT_W'(poc_pkg::BUCKET_SLOTS);

    // Memories
    logic [poc_pkg::LEAF_BITS:0]  pm_mem   [poc_pkg::ADDR_SPACE];
    poc_pkg::slot_t               tree_mem [poc_pkg::SLOT_COUNT];
    poc_pkg::blk_t                st_mem   [poc_pkg::STASH_DEPTH];

    logic [poc_pkg::LEAF_BITS:0]  pm_q;
    poc_pkg::slot_t               tree_q;
    poc_pkg::blk_t                st_q;

    // Access registers
    poc_pkg::req_t                 cur_reg;
    logic                          mapped_reg;
    logic [poc_pkg::LEAF_BITS-1:0] leaf_reg;
    logic                          found_reg;
    logic [poc_pkg::STASH_W-1:0]   f_reg;
    logic [poc_pkg::DATA_BITS-1:0] fd_reg, rd_reg;
    logic [poc_pkg::META_BITS-1:0] fm_reg, rm_reg;
    logic                          hit_reg;
    logic                          drop_reg;
    logic [poc_pkg::STASH_DEPTH-1:0] sv_reg, sv_next;
    logic                          out_valid_reg;
    poc_pkg::rsp_t                 rsp_reg;

    // Write ports
    logic                          pm_we;
    logic [poc_pkg::ADDR_BITS-1:0] pm_wa;
    logic [poc_pkg::LEAF_BITS:0]   pm_wd;
    logic                          tree_we;
    logic [poc_pkg::SLOT_W-1:0]    tree_wa, tree_ra;
    poc_pkg::slot_t                tree_wd;
    logic                          st_we;
    logic [poc_pkg::STASH_W-1:0]   st_wa;
    poc_pkg::blk_t                 st_wd;

    logic                          free_ok;
    logic [poc_pkg::STASH_W-1:0]   free_idx;
    logic                          leaf_ok;
    logic                          upd_put;
    poc_pkg::blk_t                 upd_blk;

    // First free stash entry
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = poc_pkg::STASH_DEPTH - 1; i >= 0; i--)
        begin
            if (!sv_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = poc_pkg::STASH_W'(i);
            end
        end
    end

    assign leaf_ok = ((st_q.leaf ^ leaf_reg) & poc_pkg::leaf_mask(cmd.lvl)) == '0;
    assign tree_ra = poc_pkg::slot_index(leaf_reg, cmd.lvl, cmd.slot);

    // Status
    always_comb
    begin
        stat.skip     = !cur_reg.action && !pm_q[poc_pkg::LEAF_BITS];
        stat.match    = cmd.find_chk && sv_reg[cmd.chk_k] && (st_q.addr == cur_reg.addr);
        stat.take     = cmd.wb_chk && sv_reg[cmd.chk_k] && leaf_ok && (cmd.slot < SLOTS);
        stat.out_room = !out_valid_reg || rsp_ready;
    end

    // Block written back to the stash by the update step
    always_comb
    begin
        upd_blk.addr = cur_reg.addr;
        upd_blk.leaf = cur_reg.new_leaf;
        upd_blk.data = cur_reg.action ? cur_reg.write_data : fd_reg;
        upd_blk.meta = cur_reg.action ? cur_reg.write_meta : fm_reg;
        upd_put      = found_reg || (cur_reg.action && free_ok);
    end

    // Write port selection
    always_comb
    begin
        pm_we   = 1'b0;
        pm_wa   = cur_reg.addr;
        pm_wd   = {1'b1, cur_reg.new_leaf};
        tree_we = 1'b0;
        tree_wa = tree_ra;
        tree_wd = {1'b0, st_q};
        st_we   = 1'b0;
        st_wa   = free_idx;
        st_wd   = tree_q.blk;
        sv_next = sv_reg;
        if (cmd.clr_wr)
        begin
            pm_we   = {1'b0, cmd.clr_idx} < (poc_pkg::CLR_W + 1)'(poc_pkg::ADDR_SPACE);
            pm_wa   = cmd.clr_idx[poc_pkg::ADDR_BITS-1:0];
            pm_wd   = '0;
            tree_we = {1'b0, cmd.clr_idx} < (poc_pkg::CLR_W + 1)'(poc_pkg::SLOT_COUNT);
            tree_wa = cmd.clr_idx[poc_pkg::SLOT_W-1:0];
        end
        if (cmd.slot_put && tree_q.valid && free_ok)
        begin
            st_we             = 1'b1;
            sv_next[free_idx] = 1'b1;
        end
        if (cmd.update)
        begin
            pm_we = cur_reg.action || found_reg;
            st_wd = upd_blk;
            if (found_reg)
            begin
                st_we = 1'b1;
                st_wa = f_reg;
            end
            else if (cur_reg.action && free_ok)
            begin
                st_we             = 1'b1;
                sv_next[free_idx] = 1'b1;
            end
        end
        if (stat.take)
        begin
            tree_we            = 1'b1;
            tree_wd            = {1'b1, st_q};
            sv_next[cmd.chk_k] = 1'b0;
        end
        if (cmd.wb_fill)
        begin
            tree_we = 1'b1;
        end
    end

    // Memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[pm_wa] <= pm_wd;
        end
        if (tree_we)
        begin
            tree_mem[tree_wa] <= tree_wd;
        end
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        pm_q   <= pm_mem[cur_reg.addr];
        tree_q <= tree_mem[tree_ra];
        st_q   <= st_mem[cmd.st_k];
    end

    // Stash valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else
        begin
            sv_reg <= sv_next;
        end
    end

    // Access state and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= req;
        end
        if (cmd.pm_chk)
        begin
            mapped_reg <= pm_q[poc_pkg::LEAF_BITS];
            leaf_reg   <= pm_q[poc_pkg::LEAF_BITS] ? pm_q[poc_pkg::LEAF_BITS-1:0] : '0;
            found_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            drop_reg   <= 1'b0;
            rd_reg     <= '0;
            rm_reg     <= '0;
        end
        if (cmd.slot_put && tree_q.valid && !free_ok)
        begin
            drop_reg <= 1'b1;
        end
        if (stat.match)
        begin
            found_reg <= 1'b1;
            f_reg     <= cmd.chk_k;
            fd_reg    <= st_q.data;
            fm_reg    <= st_q.meta;
        end
        if (cmd.update)
        begin
            hit_reg <= mapped_reg && found_reg;
            rd_reg  <= upd_put ? upd_blk.data : '0;
            rm_reg  <= upd_put ? upd_blk.meta : '0;
            if (cur_reg.action && !found_reg && !free_ok)
            begin
                drop_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.read_data  <= rd_reg;
            rsp_reg.read_meta  <= rm_reg;
            rsp_reg.hit        <= hit_reg;
            rsp_reg.old_leaf   <= leaf_reg;
            rsp_reg.stash_full <= drop_reg;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/path_oram_controller_unit.sv]
// Path ORAM controller: one access word in, one result word out, one access at a time.
// The time from accept to result valid is set by the stash scans, which read one stash entry
// per cycle through the stash read port. The next word can be taken in the cycle after the
// result is loaded. Reset: asynchronous, active low; a clearing pass then empties the
// position map and tree before the first word.
`include "path_oram_controller_unit_assert.svh"
module path_oram_controller_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  poc_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output poc_pkg::rsp_t  rsp
);

    poc_pkg::cmd_t  cmd;
    poc_pkg::stat_t stat;

    poc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    poc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // One access in flight: no new word right after one is taken
    `POC_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready)
    // Result word is only loaded when the output register has room
    `POC_NEVER(a_out_overrun, cmd.out_load && !stat.out_room)
    // At most one stash write source per cycle
    `POC_ASSERT(a_stash_one_src, $onehot0({cmd.slot_put, cmd.update, cmd.wb_chk}))

endmodule
